### rtl/core/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types, widths and codes for the plus-shape level-set pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

    // Input coordinate width and configuration register width.
    localparam int COORD_W = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_PERIOD = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam int               REG_LENGTH = 2;

    // Lengths are held in half-LSB units.
    localparam int LEN_W   = 17;   // folded coordinate, B/2, A
    localparam int REACH_W = 18;   // C + B/2
    localparam int DIFF_W  = 17;   // magnitude of a root argument
    localparam int SQ_W    = 34;   // square of a root argument
    localparam int RAD_W   = 36;   // radicand, padded to an even width
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 1;
    localparam int STR_W   = 20;   // straight edge distance, signed
    localparam int VAL_W   = 21;   // final combine, signed
    localparam int OUT_W   = 18;

    localparam logic signed [VAL_W-1:0] OUT_MAX = 21'sd131071;
    localparam logic signed [VAL_W-1:0] OUT_MIN = -21'sd131072;

    // How the base term is formed from the first root.
    localparam logic [1:0] KIND_STRAIGHT = 2'd0;
    localparam logic [1:0] KIND_ROOT_POS = 2'd1;
    localparam logic [1:0] KIND_ROOT_NEG = 2'd2;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [STR_W-1:0]   straight;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

    // Magnitude of the difference of two lengths.
    function automatic logic [DIFF_W-1:0] abs_diff(input logic [REACH_W-1:0] a,
                                                   input logic [REACH_W-1:0] b);
        logic [REACH_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d[DIFF_W-1:0];
    endfunction

endpackage

### rtl/core/plus_shape_signed_distance.sv
// ----------------------------------------------------------------------------
// plus_shape_signed_distance
// Level-set value of a plus-shaped region maxed with a circle term.
// ----------------------------------------------------------------------------
// Throughput: one point per cycle; busy stays low, the pipeline never stalls.
// Depth: front end, two parallel square-root pipelines, output register.
// Reset clears all valid bits and loads the register defaults.
// The receiver cannot stall: each result shows for one cycle with done high.
module plus_shape_signed_distance #(
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [psd_pkg::COORD_W-1:0] coord_s,
    input  logic signed [psd_pkg::COORD_W-1:0] coord_t,
    output logic                               done,
    output logic signed [psd_pkg::OUT_W-1:0]   level_value,
    input  logic                               cfg_we,
    input  logic [psd_pkg::IDX_W-1:0]          cfg_index,
    input  logic [psd_pkg::CFG_W-1:0]          cfg_data
);
    import psd_pkg::*;

    localparam int WIDTH_RST  = 1 << COORD_FRAC_BITS;
    localparam int LENGTH_RST = 2 << COORD_FRAC_BITS;

    // Configuration registers.
    logic [CFG_W-1:0] period_reg, width_reg, length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
            width_reg  <= CFG_W'(WIDTH_RST);
            length_reg <= CFG_W'(LENGTH_RST);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_PERIOD)
            begin
                period_reg <= cfg_data;
            end
            else if (cfg_index == REG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else if (cfg_index == IDX_W'(REG_LENGTH))
            begin
                length_reg <= cfg_data;
            end
        end
    end

    assign busy = 1'b0;

    // Front end: fold, classify, square and sum.
    logic             f_valid;
    logic [RAD_W-1:0] f_base_rad, f_circ_rad;
    side_t            f_side;

    psd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .coord_s    (coord_s),
        .coord_t    (coord_t),
        .period_val (period_reg),
        .arm_width  (width_reg),
        .arm_length (length_reg),
        .out_valid  (f_valid),
        .base_rad   (f_base_rad),
        .circ_rad   (f_circ_rad),
        .side       (f_side)
    );

    // Two roots in lockstep; the side band rides with the base root.
    logic              b_valid, c_valid;
    logic [ROOT_W-1:0] b_root, c_root;
    logic [SIDE_W-1:0] b_side_bits;
    logic              c_side_bit;
    side_t             b_side;

    psd_isqrt #(.SIDE_BITS(SIDE_W)) u_base_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .radicand  (f_base_rad),
        .in_side   (f_side),
        .out_valid (b_valid),
        .root      (b_root),
        .out_side  (b_side_bits)
    );

    psd_isqrt #(.SIDE_BITS(1)) u_circ_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .radicand  (f_circ_rad),
        .in_side   (f_valid),
        .out_valid (c_valid),
        .root      (c_root),
        .out_side  (c_side_bit)
    );

    assign b_side = side_t'(b_side_bits);

    // Final combine: base term, circle term, maximum, rounding and saturation.
    logic signed [VAL_W-1:0] base_v, circ_v, max_v, half_v, sat_v;
    logic [REACH_W-1:0]      reach;

    always_comb
    begin
        reach = REACH_W'({length_reg, 1'b0}) + REACH_W'(width_reg);
        unique case (b_side.kind)
            KIND_ROOT_POS: base_v = $signed(VAL_W'(b_root));
            KIND_ROOT_NEG: base_v = -$signed(VAL_W'(b_root));
            default:       base_v = VAL_W'(b_side.straight);
        endcase
        circ_v = $signed(VAL_W'(reach)) - $signed(VAL_W'({period_reg, 1'b0}))
                 - $signed(VAL_W'(c_root));
        max_v  = (base_v > circ_v) ? base_v : circ_v;
        half_v = (max_v + 21'sd1) >>> 1;
        priority if (half_v > OUT_MAX)
        begin
            sat_v = OUT_MAX;
        end
        else if (half_v < OUT_MIN)
        begin
            sat_v = OUT_MIN;
        end
        else
        begin
            sat_v = half_v;
        end
    end

    logic                    done_reg;
    logic signed [OUT_W-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= b_valid & c_valid & c_side_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= sat_v[OUT_W-1:0];
    end

    assign done        = done_reg;
    assign level_value = value_reg;

endmodule

### rtl/core/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Folds the point, picks the region case and forms both radicands (4 stages).
// ----------------------------------------------------------------------------
module psd_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [psd_pkg::COORD_W-1:0]  coord_s,
    input  logic [psd_pkg::COORD_W-1:0]  coord_t,
    input  logic [psd_pkg::CFG_W-1:0]    period_val,
    input  logic [psd_pkg::CFG_W-1:0]    arm_width,
    input  logic [psd_pkg::CFG_W-1:0]    arm_length,
    output logic                         out_valid,
    output logic [psd_pkg::RAD_W-1:0]    base_rad,
    output logic [psd_pkg::RAD_W-1:0]    circ_rad,
    output psd_pkg::side_t               side
);
    import psd_pkg::*;

    // Stage 1: absolute values, doubled into half-LSB units.
    logic               v1_reg;
    logic [LEN_W-1:0]   as_reg, at_reg;
    logic [COORD_W-1:0] mag_s, mag_t;

    always_comb
    begin
        mag_s = coord_s[COORD_W-1] ? (~coord_s + 1'b1) : coord_s;
        mag_t = coord_t[COORD_W-1] ? (~coord_t + 1'b1) : coord_t;
    end

    // Stage 2: fold, case selection and root arguments.
    logic [LEN_W-1:0]          x, y, h, a;
    logic [REACH_W-1:0]        reach;
    logic signed [STR_W-1:0]   hy, rx;
    side_t                     side_next;
    logic [DIFF_W-1:0]         d0_next, d1_next, e0_next, e1_next;
    logic                      v2_reg;
    side_t                     s2_reg;
    logic [DIFF_W-1:0]         d0_reg, d1_reg, e0_reg, e1_reg;

    always_comb
    begin
        x     = (as_reg >= at_reg) ? as_reg : at_reg;
        y     = (as_reg >= at_reg) ? at_reg : as_reg;
        h     = {1'b0, arm_width};
        a     = {period_val, 1'b0};
        reach = REACH_W'({arm_length, 1'b0}) + REACH_W'(arm_width);
        hy    = $signed(STR_W'(h)) - $signed(STR_W'(y));
        rx    = $signed(STR_W'(reach)) - $signed(STR_W'(x));
        side_next.kind     = KIND_STRAIGHT;
        side_next.straight = rx;
        d0_next = '0;
        d1_next = '0;
        if (x <= h)
        begin
            side_next.kind = KIND_ROOT_POS;
            d0_next = abs_diff(REACH_W'(x), REACH_W'(h));
            d1_next = abs_diff(REACH_W'(y), REACH_W'(h));
        end
        else if (REACH_W'(x) <= reach)
        begin
            if (y <= h)
            begin
                side_next.straight = (hy < rx) ? hy : rx;
            end
            else
            begin
                side_next.straight = hy;
            end
        end
        else if (y > h)
        begin
            side_next.kind = KIND_ROOT_NEG;
            d0_next = abs_diff(REACH_W'(x), reach);
            d1_next = abs_diff(REACH_W'(y), REACH_W'(h));
        end
        e0_next = abs_diff(REACH_W'(as_reg), REACH_W'(a));
        e1_next = abs_diff(REACH_W'(at_reg), REACH_W'(a));
    end

    // Stage 3: squares.
    logic            v3_reg;
    side_t           s3_reg;
    logic [SQ_W-1:0] q0_reg, q1_reg, q2_reg, q3_reg;

    // Stage 4: sums of squares.
    logic             v4_reg;
    side_t            s4_reg;
    logic [RAD_W-1:0] br_reg, cr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        as_reg <= {mag_s, 1'b0};
        at_reg <= {mag_t, 1'b0};
        s2_reg <= side_next;
        d0_reg <= d0_next;
        d1_reg <= d1_next;
        e0_reg <= e0_next;
        e1_reg <= e1_next;
        s3_reg <= s2_reg;
        q0_reg <= d0_reg * d0_reg;
        q1_reg <= d1_reg * d1_reg;
        q2_reg <= e0_reg * e0_reg;
        q3_reg <= e1_reg * e1_reg;
        s4_reg <= s3_reg;
        br_reg <= RAD_W'(q0_reg) + RAD_W'(q1_reg);
        cr_reg <= RAD_W'(q2_reg) + RAD_W'(q3_reg);
    end

    assign out_valid = v4_reg;
    assign base_rad  = br_reg;
    assign circ_rad  = cr_reg;
    assign side      = s4_reg;

endmodule

### rtl/core/psd_isqrt.sv
// ----------------------------------------------------------------------------
// psd_isqrt
// Pipelined square root, one result bit per stage, rounded to nearest.
// ----------------------------------------------------------------------------
module psd_isqrt #(
    parameter int SIDE_BITS = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [psd_pkg::RAD_W-1:0]    radicand,
    input  logic [SIDE_BITS-1:0]         in_side,
    output logic                         out_valid,
    output logic [psd_pkg::ROOT_W-1:0]   root,
    output logic [SIDE_BITS-1:0]         out_side
);
    import psd_pkg::*;

    logic                 vld_reg  [0:ROOT_W-1];
    logic [RAD_W-1:0]     rad_reg  [0:ROOT_W-1];
    logic [REM_W-1:0]     rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0]    root_reg [0:ROOT_W-1];
    logic [SIDE_BITS-1:0] side_reg [0:ROOT_W-1];

    genvar i;
    generate
        for (i = 0; i < ROOT_W; i++)
        begin : g_stage
            logic                 vld_in;
            logic [RAD_W-1:0]     rad_in;
            logic [REM_W-1:0]     rem_in;
            logic [ROOT_W-1:0]    root_in;
            logic [SIDE_BITS-1:0] side_in;
            logic [REM_W+1:0]     rem_sh, trial;
            logic [REM_W-1:0]     rem_next;
            logic [ROOT_W-1:0]    root_next;

            if (i == 0)
            begin : g_first
                assign vld_in  = in_valid;
                assign rad_in  = radicand;
                assign rem_in  = '0;
                assign root_in = '0;
                assign side_in = in_side;
            end
            else
            begin : g_rest
                assign vld_in  = vld_reg[i-1];
                assign rad_in  = rad_reg[i-1];
                assign rem_in  = rem_reg[i-1];
                assign root_in = root_reg[i-1];
                assign side_in = side_reg[i-1];
            end

            // One restoring step: bring down two radicand bits, try a 1 bit.
            always_comb
            begin
                rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
                trial  = (REM_W+2)'({root_in, 2'b01});
                if (rem_sh >= trial)
                begin
                    rem_next  = REM_W'(rem_sh - trial);
                    root_next = {root_in[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = REM_W'(rem_sh);
                    root_next = {root_in[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else
                begin
                    vld_reg[i] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rad_reg[i]  <= {rad_in[RAD_W-3:0], 2'b00};
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                side_reg[i] <= side_in;
            end
        end
    endgenerate

    // Round to nearest: the remainder is q - r*r, so round up when it exceeds r.
    logic                 rv_reg;
    logic [ROOT_W-1:0]    rr_reg;
    logic [SIDE_BITS-1:0] rs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
        end
        else
        begin
            rv_reg <= vld_reg[ROOT_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        rr_reg <= root_reg[ROOT_W-1] +
                  ROOT_W'(rem_reg[ROOT_W-1] > REM_W'(root_reg[ROOT_W-1]));
        rs_reg <= side_reg[ROOT_W-1];
    end

    assign out_valid = rv_reg;
    assign root      = rr_reg;
    assign out_side  = rs_reg;

endmodule

### test/plus_shape_signed_distance_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plus_shape_signed_distance_test
// Self-checking bench for the plus-shape level-set block. Directed points and
// random bursts are sent, each result is compared with a predicted value computed in
// half-LSB units, and the register settings change between phases while the
// pipeline is drained.
// ----------------------------------------------------------------------------
module plus_shape_signed_distance_test;

    import psd_pkg::*;

    localparam int PIPE_LAT  = 24;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 1400;
    localparam int N_ROWS    = 18;
    localparam int NO_CHECK  = 32'h7FFFFFFF;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [COORD_W-1:0] coord_s;
    logic signed [COORD_W-1:0] coord_t;
    logic                      done;
    logic signed [OUT_W-1:0]   level_value;
    logic                      cfg_we;
    logic [IDX_W-1:0]          cfg_index;
    logic [CFG_W-1:0]          cfg_data;

    // Shadow copy of the registers used by the predictor.
    logic [CFG_W-1:0] period_reg;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] length_reg;

    logic signed [OUT_W-1:0] level_queue[$];
    int mismatches;
    int wdog;
    bit timed_out;

    typedef struct {
        logic [15:0] s;
        logic [15:0] t;
        int          known;   // typed-in expected value, or NO_CHECK
    } point_row_t;

    point_row_t rows [N_ROWS];

    plus_shape_signed_distance uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .coord_s     (coord_s),
        .coord_t     (coord_t),
        .done        (done),
        .level_value (level_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Clock: 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Integer square root of a*a + b*b, rounded to nearest.
    function automatic longint round_root(input longint a, input longint b);
        longint unsigned q;
        longint unsigned n;
        longint unsigned res;
        longint unsigned bitv;
        q = a * a + b * b;
        n = q;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        if (q - res * res > res)
            res = res + 1;
        return longint'(res);
    endfunction

    // Predicted level value of one point under the current settings.
    function automatic logic signed [OUT_W-1:0] plus_level(input logic [15:0] s,
                                                           input logic [15:0] t);
        longint as_h, at_h, half_w, reach, ofs, x, y, base, circ, v, n, q;
        as_h = 2 * ((s[15]) ? -longint'($signed(s)) : longint'($signed(s)));
        at_h = 2 * ((t[15]) ? -longint'($signed(t)) : longint'($signed(t)));
        half_w = longint'(width_reg);
        reach = 2 * longint'(length_reg) + half_w;
        ofs = 2 * longint'(period_reg);
        x = (as_h > at_h) ? as_h : at_h;
        y = (as_h > at_h) ? at_h : as_h;
        if (x <= half_w)
            base = round_root(x - half_w, y - half_w);
        else if (x <= reach)
        begin
            if (y <= half_w)
                base = (half_w - y < reach - x) ? half_w - y : reach - x;
            else
                base = half_w - y;
        end
        else if (y <= half_w)
            base = reach - x;
        else
            base = -round_root(x - reach, y - half_w);
        circ = reach - ofs - round_root(as_h - ofs, at_h - ofs);
        v = (base > circ) ? base : circ;
        n = v + 1;
        q = (n >= 0) ? n / 2 : -((-n + 1) / 2);
        if (q > 131071)
            q = 131071;
        if (q < -131072)
            q = -131072;
        return q[OUT_W-1:0];
    endfunction

    // Drive one point and wait for its start beat to be taken.
    task automatic send_point(input logic [15:0] s, input logic [15:0] t, input int known);
        logic signed [OUT_W-1:0] predicted;
        predicted = plus_level(s, t);
        if (known != NO_CHECK && int'(predicted) != known)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("table value %0d disagrees with prediction %0d", known, predicted);
        end
        start <= 1'b1;
        coord_s <= s;
        coord_t <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        level_queue.push_back(predicted);
        @(negedge clk);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Wait for the pipeline to empty, then let it idle before returning.
    task automatic drain;
        start <= 1'b0;
        while (level_queue.size() != 0)
            @(negedge clk);
        repeat (PIPE_LAT + 4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_PERIOD)
            period_reg = val;
        else if (idx == REG_WIDTH)
            width_reg = val;
        else if (idx == IDX_W'(REG_LENGTH))
            length_reg = val;
    endtask

    // Random point: mostly near the shape, sometimes anywhere.
    task automatic random_point;
        logic [15:0] s;
        logic [15:0] t;
        int span;
        span = (width_reg + length_reg) / 2 + 64;
        if (span > 32767)
            span = 32767;
        if ($urandom_range(0, 3) == 0)
        begin
            s = 16'($urandom);
            t = 16'($urandom);
        end
        else
        begin
            s = 16'($urandom_range(0, 2 * span) - span);
            t = 16'($urandom_range(0, 2 * span) - span);
        end
        send_point(s, t, NO_CHECK);
    endtask

    // One phase of random traffic in bursts with gaps.
    task automatic random_phase(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && sent < count)
            begin
                random_point();
                burst--;
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 6));
        end
        drain();
    endtask

    // Result checker: compare every done beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (level_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %0d", level_value);
            end
            else if (level_value !== level_queue[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("level mismatch: expected %0d got %0d",
                             level_queue[0], level_value);
                void'(level_queue.pop_front());
            end
            else
                void'(level_queue.pop_front());
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX && !timed_out)
        begin
            timed_out = 1'b1;
            $display("[plus_shape_signed_distance] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        coord_s = '0;
        coord_t = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        timed_out = 1'b0;
        wdog = 0;
        period_reg = 16'd0;
        width_reg = 16'd256;
        length_reg = 16'd512;

        // Directed points under the reset settings; values at a glance where easy.
        rows[0]  = '{16'h0000, 16'h0000, NO_CHECK};
        rows[1]  = '{16'h0080, 16'h0080, NO_CHECK};
        rows[2]  = '{16'h0080, 16'h0000, 512};
        rows[3]  = '{16'h0200, 16'h0000, NO_CHECK};
        rows[4]  = '{16'h0280, 16'h0000, 0};
        rows[5]  = '{16'h0000, 16'hFD80, 0};
        rows[6]  = '{16'h0200, 16'h0100, NO_CHECK};
        rows[7]  = '{16'h0300, 16'h0300, NO_CHECK};
        rows[8]  = '{16'h8000, 16'h0000, NO_CHECK};
        rows[9]  = '{16'h0000, 16'h8000, NO_CHECK};
        rows[10] = '{16'h8000, 16'h8000, NO_CHECK};
        rows[11] = '{16'h7FFF, 16'h7FFF, NO_CHECK};
        rows[12] = '{16'h7FFF, 16'h8000, NO_CHECK};
        rows[13] = '{16'hFFFF, 16'h0001, NO_CHECK};
        rows[14] = '{16'hFF80, 16'hFF80, NO_CHECK};
        rows[15] = '{16'h5555, 16'hAAAA, NO_CHECK};
        rows[16] = '{16'hAAAA, 16'h5555, NO_CHECK};
        rows[17] = '{16'h0100, 16'h0100, NO_CHECK};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_ROWS; i++)
            send_point(rows[i].s, rows[i].t, rows[i].known);
        drain();

        // Extreme settings: widest arms give the largest circle term, then zero width.
        write_reg(REG_PERIOD, 16'h0000);
        write_reg(REG_WIDTH, 16'hFFFF);
        write_reg(IDX_W'(REG_LENGTH), 16'hFFFF);
        write_reg(2'd3, 16'h1234);
        send_point(16'h0000, 16'h0000, 98303);
        send_point(16'h8000, 16'h8000, NO_CHECK);
        drain();
        write_reg(REG_WIDTH, 16'h0000);
        write_reg(IDX_W'(REG_LENGTH), 16'h0000);
        write_reg(REG_PERIOD, 16'hFFFF);
        send_point(16'h0000, 16'h0000, NO_CHECK);
        send_point(16'h8000, 16'h7FFF, NO_CHECK);
        send_point(16'h7FFF, 16'h7FFF, NO_CHECK);
        drain();

        // Random phases under several settings, the reset values included.
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(REG_PERIOD, 16'd0);
                    write_reg(REG_WIDTH, 16'd256);
                    write_reg(IDX_W'(REG_LENGTH), 16'd512);
                end
                1:
                begin
                    write_reg(REG_WIDTH, 16'd0);
                    write_reg(IDX_W'(REG_LENGTH), 16'd0);
                end
                2:
                begin
                    write_reg(REG_PERIOD, 16'hFFFF);
                    write_reg(REG_WIDTH, 16'hFFFF);
                    write_reg(IDX_W'(REG_LENGTH), 16'hFFFF);
                end
                default:
                begin
                    write_reg(REG_PERIOD, 16'($urandom));
                    write_reg(REG_WIDTH, 16'($urandom_range(0, 4095)));
                    write_reg(IDX_W'(REG_LENGTH), 16'($urandom));
                end
            endcase
            random_phase(N_RANDOM / 7);
        end

        drain();
        if (mismatches == 0 && level_queue.size() == 0)
            $display("[plus_shape_signed_distance] OK");
        else
            $display("[plus_shape_signed_distance] ERROR");
        $finish;
    end

endmodule
